// ===== rtl/stream_pattern_replace_macros.svh =====
// ----------------------------------------------------------------------------
// stream_pattern_replace assertion macros
// Shared assertion wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STREAM_PATTERN_REPLACE_MACROS_SVH
`define STREAM_PATTERN_REPLACE_MACROS_SVH

// Same-cycle implication.
`define SPR_ASSERT_IMP(name, ante, cons) \
name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stream_pattern_replace: same-cycle check failed");

// Next-cycle implication.
`define SPR_ASSERT_NEXT(name, ante, cons) \
name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stream_pattern_replace: next-cycle check failed");

`endif

// ===== rtl/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// spr_pkg
// Types, constants and helpers shared by the pattern replace block.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int MAX_PATTERN_DEF     = 8;
    localparam int MAX_REPLACEMENT_DEF = 8;
    localparam int QUEUE_DEPTH         = 2;
    localparam int CFG_DATA_W          = 64;
    localparam int CFG_ADDR_W          = 5;

    // Register indexes on the configuration port (byte address is 8 * index).
    typedef enum logic [1:0] {
        REG_PATTERN_BYTES     = 2'd0,
        REG_PATTERN_LEN       = 2'd1,
        REG_REPLACEMENT_BYTES = 2'd2,
        REG_REPLACEMENT_LEN   = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_REPL,
        ST_LIT,
        ST_FLUSH,
        ST_DONE
    } back_state_t;

    // One queued source byte.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } front_status_t;

    // Request from the sequencer to the output stage.
    typedef struct packed {
        logic       emit;
        logic       fin;
        logic [7:0] data;
        logic       str_end;
    } push_t;

    typedef struct packed {
        back_state_t state;
        logic        held_at_max;
    } back_status_t;

    typedef struct packed {
        logic pend_valid;
        logic ready;
    } out_status_t;

    function automatic logic [7:0] byte_at(logic [63:0] word, logic [2:0] idx);
        return word[{idx, 3'b000} +: 8];
    endfunction

endpackage

// ===== rtl/spr_front.sv =====
// ----------------------------------------------------------------------------
// spr_front
// Input side: accepts source bytes and queues them for the sequencer.
// ----------------------------------------------------------------------------
module spr_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   src_valid,
    input  logic [7:0]             in_byte,
    input  logic                   in_end,
    output logic                   src_stall,
    input  logic                   pop,
    output spr_pkg::item_t         item,
    output spr_pkg::front_status_t status
);

    localparam int PW = (spr_pkg::QUEUE_DEPTH > 1) ? $clog2(spr_pkg::QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(spr_pkg::QUEUE_DEPTH + 1);

    spr_pkg::item_t  q_mem_reg [spr_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wptr_reg;
    logic [PW-1:0]   wptr_next;
    logic [PW-1:0]   rptr_reg;
    logic [PW-1:0]   rptr_next;
    logic [NW-1:0]   cnt_reg;
    logic [NW-1:0]   cnt_next;
    logic            push_in;
    logic            pop_out;

    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == NW'(spr_pkg::QUEUE_DEPTH));
    assign src_stall    = status.full;
    assign push_in      = src_valid && !status.full;
    assign pop_out      = pop && !status.empty;
    assign item         = q_mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push_in)
        begin
            wptr_next = (wptr_reg == PW'(spr_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop_out)
        begin
            rptr_next = (rptr_reg == PW'(spr_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push_in && !pop_out)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop_out && !push_in)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_in)
        begin
            q_mem_reg[wptr_reg] <= '{data: in_byte, last: in_end};
        end
    end

endmodule

// ===== rtl/spr_back.sv =====
// ----------------------------------------------------------------------------
// spr_back
// Sequencer: holds candidate bytes, matches them against the pattern and
// issues at most one output request per cycle while the output stage is ready.
// ----------------------------------------------------------------------------
module spr_back #(
    parameter int MAX_PATTERN     = spr_pkg::MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = spr_pkg::MAX_REPLACEMENT_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  spr_pkg::item_t         item,
    input  spr_pkg::front_status_t q_status,
    output logic                   pop,
    input  logic [63:0]            pattern_bytes,
    input  logic [3:0]             pattern_len,
    input  logic [63:0]            replacement_bytes,
    input  logic [3:0]             replacement_len,
    input  spr_pkg::out_status_t   out_st,
    output spr_pkg::push_t         push,
    output spr_pkg::back_status_t  status
);

    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam int RW = $clog2(MAX_REPLACEMENT + 2);

    spr_pkg::back_state_t state_reg;
    spr_pkg::back_state_t state_next;
    spr_pkg::back_state_t after_state;
    logic [7:0]           held_reg  [MAX_PATTERN];
    logic [7:0]           held_next [MAX_PATTERN];
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [RW-1:0]        ridx_reg;
    logic [RW-1:0]        ridx_next;
    logic [7:0]           byte_reg;
    logic [7:0]           byte_next;
    logic                 end_reg;
    logic                 end_next;
    logic [CW-1:0]        plen;
    logic [RW-1:0]        rlen;
    logic                 prefix_ok;
    logic                 do_shift;

    assign plen = (pattern_len > 4'(MAX_PATTERN)) ? CW'(MAX_PATTERN) : CW'(pattern_len);
    assign rlen = (replacement_len > 4'(MAX_REPLACEMENT)) ?
                  RW'(MAX_REPLACEMENT) : RW'(replacement_len);
    assign after_state = end_reg ? spr_pkg::ST_FLUSH : spr_pkg::ST_DONE;

    assign status.state       = state_reg;
    assign status.held_at_max = (count_reg >= CW'(MAX_PATTERN));

    // All held bytes agree with the start of the pattern.
    always_comb
    begin
        prefix_ok = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((CW'(i) < count_reg) && (held_reg[i] != pattern_bytes[8*i +: 8]))
            begin
                prefix_ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        held_next  = held_reg;
        count_next = count_reg;
        ridx_next  = ridx_reg;
        byte_next  = byte_reg;
        end_next   = end_reg;
        pop        = 1'b0;
        push       = '0;
        do_shift   = 1'b0;

        case (state_reg)
            spr_pkg::ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop       = 1'b1;
                    byte_next = item.data;
                    end_next  = item.last;
                    ridx_next = '0;
                    if (plen == '0)
                    begin
                        state_next = spr_pkg::ST_DRAIN;
                    end
                    else
                    begin
                        for (int i = 0; i < MAX_PATTERN; i++)
                        begin
                            if (count_reg == CW'(i))
                            begin
                                held_next[i] = item.data;
                            end
                        end
                        count_next = count_reg + 1'b1;
                        state_next = spr_pkg::ST_SCAN;
                    end
                end
            end
            spr_pkg::ST_SCAN:
            begin
                if (out_st.ready)
                begin
                    if (count_reg == '0)
                    begin
                        state_next = after_state;
                    end
                    else if (count_reg > plen)
                    begin
                        do_shift = 1'b1;
                    end
                    else if (prefix_ok && (count_reg == plen))
                    begin
                        count_next = '0;
                        ridx_next  = '0;
                        state_next = spr_pkg::ST_REPL;
                    end
                    else if (prefix_ok)
                    begin
                        state_next = after_state;
                    end
                    else
                    begin
                        do_shift = 1'b1;
                    end
                end
            end
            spr_pkg::ST_DRAIN:
            begin
                if (out_st.ready)
                begin
                    if (count_reg == '0)
                    begin
                        state_next = spr_pkg::ST_REPL;
                    end
                    else
                    begin
                        do_shift = 1'b1;
                    end
                end
            end
            spr_pkg::ST_REPL:
            begin
                if (out_st.ready)
                begin
                    if (ridx_reg == rlen)
                    begin
                        state_next = (plen == '0) ? spr_pkg::ST_LIT : after_state;
                    end
                    else
                    begin
                        push.emit = 1'b1;
                        push.data = spr_pkg::byte_at(replacement_bytes, 3'(ridx_reg));
                        ridx_next = ridx_reg + 1'b1;
                    end
                end
            end
            spr_pkg::ST_LIT:
            begin
                if (out_st.ready)
                begin
                    push.emit  = 1'b1;
                    push.data  = byte_reg;
                    state_next = after_state;
                end
            end
            spr_pkg::ST_FLUSH:
            begin
                if (out_st.ready)
                begin
                    if (count_reg == '0)
                    begin
                        state_next = spr_pkg::ST_DONE;
                    end
                    else
                    begin
                        do_shift = 1'b1;
                    end
                end
            end
            spr_pkg::ST_DONE:
            begin
                if (out_st.ready)
                begin
                    push.fin     = 1'b1;
                    push.str_end = end_reg;
                    state_next   = spr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spr_pkg::ST_IDLE;
            end
        endcase

        // Release the oldest held byte and move the rest down.
        if (do_shift)
        begin
            push.emit = 1'b1;
            push.data = held_reg[0];
            for (int i = 0; i < MAX_PATTERN - 1; i++)
            begin
                held_next[i] = held_reg[i + 1];
            end
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spr_pkg::ST_IDLE;
            count_reg <= '0;
            ridx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ridx_reg  <= ridx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        byte_reg <= byte_next;
        end_reg  <= end_next;
    end

endmodule

// ===== rtl/spr_out.sv =====
// ----------------------------------------------------------------------------
// spr_out
// Output side: keeps the latest byte back one step so its run_last and
// string_end flags are known, then presents it in the output register.
// ----------------------------------------------------------------------------
module spr_out (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spr_pkg::push_t       push,
    input  logic                 dst_stall,
    output logic                 dst_valid,
    output logic [7:0]           out_byte,
    output logic                 out_valid,
    output logic                 string_end,
    output logic                 run_last,
    output spr_pkg::out_status_t status
);

    logic       pend_valid_reg;
    logic       pend_valid_next;
    logic [7:0] pend_byte_reg;
    logic [7:0] pend_byte_next;
    logic       full_reg;
    logic       full_next;
    logic [7:0] ob_reg;
    logic [7:0] ob_next;
    logic       ov_reg;
    logic       ov_next;
    logic       se_reg;
    logic       se_next;
    logic       rl_reg;
    logic       rl_next;
    logic       out_free;
    logic       load;

    assign out_free          = !full_reg || !dst_stall;
    assign status.pend_valid = pend_valid_reg;
    assign status.ready      = out_free;

    assign dst_valid  = full_reg;
    assign out_byte   = ob_reg;
    assign out_valid  = ov_reg;
    assign string_end = se_reg;
    assign run_last   = rl_reg;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        load            = 1'b0;
        ob_next         = ob_reg;
        ov_next         = ov_reg;
        se_next         = se_reg;
        rl_next         = rl_reg;

        if (push.emit)
        begin
            if (pend_valid_reg)
            begin
                load    = 1'b1;
                ob_next = pend_byte_reg;
                ov_next = 1'b1;
                se_next = 1'b0;
                rl_next = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_byte_next  = push.data;
        end
        else if (push.fin)
        begin
            if (pend_valid_reg)
            begin
                load            = 1'b1;
                ob_next         = pend_byte_reg;
                ov_next         = 1'b1;
                se_next         = push.str_end;
                rl_next         = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (push.str_end)
            begin
                // Nothing was produced for the closing byte: send a bare marker.
                load    = 1'b1;
                ob_next = '0;
                ov_next = 1'b0;
                se_next = 1'b1;
                rl_next = 1'b1;
            end
        end

        if (load)
        begin
            full_next = 1'b1;
        end
        else if (out_free)
        begin
            full_next = 1'b0;
        end
        else
        begin
            full_next = full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            full_reg       <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            full_reg       <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_byte_reg <= pend_byte_next;
        ob_reg        <= ob_next;
        ov_reg        <= ov_next;
        se_reg        <= se_next;
        rl_reg        <= rl_next;
    end

endmodule

// ===== rtl/stream_pattern_replace.sv =====
// ----------------------------------------------------------------------------
// stream_pattern_replace
// Streaming find-and-replace of a configured pattern over a byte string.
// ----------------------------------------------------------------------------
// Usage:
// Source bytes enter on the src channel (src_valid, src_stall, in_byte,
// in_end); a transaction completes on a clock edge with src_valid high and
// src_stall low. in_end marks the last byte of a string. Results leave on the
// dst channel (dst_valid, dst_stall) with out_byte, out_valid, string_end and
// run_last. A closing byte that leaves nothing to send produces one bare
// marker transaction with out_valid low.
// Configuration is written over the APB port while no transaction is in
// flight; registers sit at byte addresses 0, 8, 16 and 24.
// The sequencer takes a new byte from the queue only once it is through with
// the last one, and issues at most one result per cycle while the output
// stage is ready; a full match or an empty pattern adds the replacement
// bytes, and the closing byte of a string also flushes the held bytes.
// A two-entry input queue lets the source run ahead while the sequencer
// works, and the output register holds a result while dst_stall is high;
// a stalled receiver pauses the sequencer and, once the queue fills, the
// source. Reset empties the queue, the held bytes and the output register
// and clears all configuration registers to zero.
// ----------------------------------------------------------------------------
`include "stream_pattern_replace_macros.svh"

module stream_pattern_replace #(
    parameter int MAX_PATTERN     = spr_pkg::MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = spr_pkg::MAX_REPLACEMENT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Source channel
    input  logic                           src_valid,
    output logic                           src_stall,
    input  logic [7:0]                     in_byte,
    input  logic                           in_end,
    // Result channel
    output logic                           dst_valid,
    input  logic                           dst_stall,
    output logic [7:0]                     out_byte,
    output logic                           out_valid,
    output logic                           string_end,
    output logic                           run_last,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [spr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [spr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic [63:0]            pattern_bytes_reg;
    logic [3:0]             pattern_len_reg;
    logic [63:0]            replacement_bytes_reg;
    logic [3:0]             replacement_len_reg;
    spr_pkg::cfg_reg_t      cfg_sel;
    logic                   cfg_write;

    spr_pkg::item_t         item;
    spr_pkg::front_status_t front_st;
    spr_pkg::back_status_t  back_st;
    spr_pkg::out_status_t   out_st;
    spr_pkg::push_t         push;
    logic                   pop;

    // Registers are eight bytes apart; the low address bits are ignored.
    assign pready    = 1'b1;
    assign cfg_sel   = spr_pkg::cfg_reg_t'(paddr[4:3]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg     <= '0;
            pattern_len_reg       <= '0;
            replacement_bytes_reg <= '0;
            replacement_len_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                spr_pkg::REG_PATTERN_BYTES:     pattern_bytes_reg     <= pwdata;
                spr_pkg::REG_PATTERN_LEN:       pattern_len_reg       <= pwdata[3:0];
                spr_pkg::REG_REPLACEMENT_BYTES: replacement_bytes_reg <= pwdata;
                spr_pkg::REG_REPLACEMENT_LEN:   replacement_len_reg   <= pwdata[3:0];
                default:                        pattern_len_reg       <= pattern_len_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            spr_pkg::REG_PATTERN_BYTES:     prdata = pattern_bytes_reg;
            spr_pkg::REG_PATTERN_LEN:       prdata = 64'(pattern_len_reg);
            spr_pkg::REG_REPLACEMENT_BYTES: prdata = replacement_bytes_reg;
            spr_pkg::REG_REPLACEMENT_LEN:   prdata = 64'(replacement_len_reg);
            default:                        prdata = '0;
        endcase
    end

    // Input queue.
    spr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .in_byte   (in_byte),
        .in_end    (in_end),
        .src_stall (src_stall),
        .pop       (pop),
        .item      (item),
        .status    (front_st)
    );

    // Match sequencer with the held candidate bytes.
    spr_back #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .item              (item),
        .q_status          (front_st),
        .pop               (pop),
        .pattern_bytes     (pattern_bytes_reg),
        .pattern_len       (pattern_len_reg),
        .replacement_bytes (replacement_bytes_reg),
        .replacement_len   (replacement_len_reg),
        .out_st            (out_st),
        .push              (push),
        .status            (back_st)
    );

    // Flag resolution and output register.
    spr_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .dst_stall  (dst_stall),
        .dst_valid  (dst_valid),
        .out_byte   (out_byte),
        .out_valid  (out_valid),
        .string_end (string_end),
        .run_last   (run_last),
        .status     (out_st)
    );

    // Between bytes fewer candidates are held than the pattern can be long.
    `SPR_ASSERT_IMP(a_held_room, back_st.state == spr_pkg::ST_IDLE, !back_st.held_at_max)
    // Every result of a byte has left the holding stage before the next byte starts.
    `SPR_ASSERT_IMP(a_pend_drained, back_st.state == spr_pkg::ST_IDLE, !out_st.pend_valid)
    // The end of a string is always the last result of its byte.
    `SPR_ASSERT_IMP(a_end_is_last, dst_valid && string_end, run_last)
    // A queued byte is always picked up by an idle sequencer.
    `SPR_ASSERT_NEXT(a_pop_starts, back_st.state == spr_pkg::ST_IDLE && !front_st.empty, back_st.state != spr_pkg::ST_IDLE)

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming pattern replace block. Byte strings go
// in on the source channel and an internal copy of the find-and-replace rules
// predicts every result transaction, which the monitor checks field by field.
// Several pattern and replacement settings are programmed over the APB port.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles allowed after the last expected result before the block counts as
    // idle. A byte that only extends a held prefix produces no result, so the
    // sequencer can still be busy when the result queue runs dry.
    localparam int SETTLE_CYCLES = 30;
    // Cycles without any accepted transaction on either channel before the run
    // is declared hung. The slowest legal stretch is a config phase plus the
    // settle time, or a long stall on a burst of results; both are far below.
    localparam int HANG_LIMIT    = 2000;
    // Minimum number of random source bytes to generate after the directed part.
    localparam int RANDOM_BYTES  = 160;

    // One source byte waiting to be driven, with the idle cycles before it.
    typedef struct {
        logic [7:0]  data;
        logic        fin;
        int unsigned gap;
    } source_byte_t;

    // One result transaction as the block should present it.
    typedef struct {
        logic [7:0] data;
        logic       valid;
        logic       str_end;
        logic       last;
    } out_result_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           src_valid = 1'b0;
    logic                           src_stall;
    logic [7:0]                     in_byte   = 8'h00;
    logic                           in_end    = 1'b0;
    logic                           dst_valid;
    logic                           dst_stall = 1'b0;
    logic [7:0]                     out_byte;
    logic                           out_valid;
    logic                           string_end;
    logic                           run_last;
    logic                           psel      = 1'b0;
    logic                           penable   = 1'b0;
    logic                           pwrite    = 1'b0;
    logic [spr_pkg::CFG_ADDR_W-1:0] paddr     = '0;
    logic [spr_pkg::CFG_DATA_W-1:0] pwdata    = '0;
    logic [spr_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    // Bytes queued by the stimulus and the results the rules predict.
    source_byte_t pending_bytes[$];
    out_result_t  expected_out[$];

    // Shadow of the configuration registers, all zero after reset.
    logic [63:0] pat_word     = '0;
    logic [3:0]  pat_len_cfg  = '0;
    logic [63:0] repl_word    = '0;
    logic [3:0]  repl_len_cfg = '0;

    // Shadow of the bytes the block holds back as a possible pattern start.
    logic [7:0] held_data [8];
    int         held_count = 0;

    // Pacing knobs; a maximum of zero gives stretches with no idling.
    int unsigned gap_max  = 8;
    int unsigned sink_max = 8;

    int unsigned src_wait   = 0;
    int unsigned dst_hold   = 0;
    bit          src_took   = 1'b0;
    int unsigned quiet      = 0;
    int unsigned mismatches = 0;

    stream_pattern_replace u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .in_byte    (in_byte),
        .in_end     (in_end),
        .dst_valid  (dst_valid),
        .dst_stall  (dst_stall),
        .out_byte   (out_byte),
        .out_valid  (out_valid),
        .string_end (string_end),
        .run_last   (run_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Replace rules
    // ------------------------------------------------------------------------

    // Append one predicted result; a bare end marker always carries zero data.
    function automatic void add_result(logic [7:0] data, logic valid);
        out_result_t r;
        r.data    = valid ? data : 8'h00;
        r.valid   = valid;
        r.str_end = 1'b0;
        r.last    = 1'b0;
        expected_out.push_back(r);
    endfunction

    // The oldest held byte is given up as plain text and the rest move down.
    function automatic void emit_oldest_held();
        int k;
        add_result(held_data[0], 1'b1);
        for (k = 0; k < 7; k++)
            held_data[k] = held_data[k + 1];
        held_count--;
    endfunction

    function automatic void add_replacement();
        int rlen;
        int k;
        rlen = (repl_len_cfg > spr_pkg::MAX_REPLACEMENT_DEF) ?
               spr_pkg::MAX_REPLACEMENT_DEF : int'(repl_len_cfg);
        for (k = 0; k < rlen; k++)
            add_result(repl_word[8*k +: 8], 1'b1);
    endfunction

    // Work out every result caused by one accepted source byte.
    function automatic void predict_byte(logic [7:0] data, logic fin);
        int          plen;
        int          first;
        int          k;
        bit          scanning;
        bit          same;
        out_result_t tail;
        plen  = (pat_len_cfg > spr_pkg::MAX_PATTERN_DEF) ?
                spr_pkg::MAX_PATTERN_DEF : int'(pat_len_cfg);
        first = expected_out.size();
        if (plen == 0)
        begin
            // An empty pattern matches in front of every byte.
            while (held_count > 0)
                emit_oldest_held();
            add_replacement();
            add_result(data, 1'b1);
        end
        else
        begin
            if (held_count >= 8)
                emit_oldest_held();
            held_data[held_count] = data;
            held_count++;
            // Rescan: drop bytes from the front until what is left is either a
            // full match or still a proper prefix of the pattern.
            scanning = 1'b1;
            while (scanning && held_count > 0)
            begin
                if (held_count > plen)
                    emit_oldest_held();
                else
                begin
                    same = 1'b1;
                    for (k = 0; k < held_count; k++)
                        if (held_data[k] != pat_word[8*k +: 8])
                            same = 1'b0;
                    if (same && held_count == plen)
                    begin
                        held_count = 0;
                        add_replacement();
                        scanning   = 1'b0;
                    end
                    else if (same)
                        scanning = 1'b0;
                    else
                        emit_oldest_held();
                end
            end
        end
        if (fin)
        begin
            while (held_count > 0)
                emit_oldest_held();
            if (expected_out.size() == first)
                add_result(8'h00, 1'b0);
            tail         = expected_out.pop_back();
            tail.str_end = 1'b1;
            expected_out.push_back(tail);
        end
        if (expected_out.size() > first)
        begin
            tail      = expected_out.pop_back();
            tail.last = 1'b1;
            expected_out.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Source driver: presents one queued byte per transaction, honoring the
    // gap drawn for it, and holds the payload steady while the block stalls.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        source_byte_t cur;
        if (!rst_n)
            src_valid <= 1'b0;
        else if (!src_valid || src_took)
        begin
            if (pending_bytes.size() == 0)
                src_valid <= 1'b0;
            else if (src_wait < pending_bytes[0].gap)
            begin
                src_wait++;
                src_valid <= 1'b0;
            end
            else
            begin
                cur       = pending_bytes.pop_front();
                src_wait  = 0;
                in_byte   <= cur.data;
                in_end    <= cur.fin;
                src_valid <= 1'b1;
            end
        end
    end

    // Result sink: stalls for the number of cycles drawn at each transaction.
    always @(negedge clk)
    begin
        if (dst_hold > 0)
        begin
            dst_stall <= 1'b1;
            dst_hold--;
        end
        else
            dst_stall <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on every accepted source transaction, checks every
    // accepted result transaction against the oldest prediction, and watches
    // for a hung block.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_result_t want;
        bit          got;
        if (rst_n)
        begin
            src_took = src_valid && !src_stall;
            got      = dst_valid && !dst_stall;
            if (src_took)
                predict_byte(in_byte, in_end);
            if (got)
            begin
                if (expected_out.size() == 0)
                begin
                    $error("unexpected result: out_byte %h out_valid %b string_end %b run_last %b",
                           out_byte, out_valid, string_end, run_last);
                    mismatches++;
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %h, got %h", want.data, out_byte);
                        mismatches++;
                    end
                    if (out_valid !== want.valid)
                    begin
                        $error("out_valid: expected %b, got %b", want.valid, out_valid);
                        mismatches++;
                    end
                    if (string_end !== want.str_end)
                    begin
                        $error("string_end: expected %b, got %b", want.str_end, string_end);
                        mismatches++;
                    end
                    if (run_last !== want.last)
                    begin
                        $error("run_last: expected %b, got %b", want.last, run_last);
                        mismatches++;
                    end
                end
                dst_hold = $urandom_range(0, sink_max);
            end
            if (src_took || got)
                quiet = 0;
            else
                quiet++;
            if (quiet >= HANG_LIMIT)
            begin
                $error("no transaction for %0d cycles, %0d results still expected",
                       quiet, expected_out.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic queue_byte(logic [7:0] data, logic fin);
        source_byte_t b;
        b.data = data;
        b.fin  = fin;
        b.gap  = $urandom_range(0, gap_max);
        pending_bytes.push_back(b);
    endtask

    task automatic send_text(string s, logic fin);
        int k;
        for (k = 0; k < s.len(); k++)
            queue_byte(s[k], fin && (k == s.len() - 1));
    endtask

    // Hold the source back until every queued byte is taken and every
    // predicted result has come out.
    task automatic wait_drain();
        while (pending_bytes.size() != 0 || src_valid || expected_out.size() != 0)
            @(posedge clk);
    endtask

    // Drain, then give the sequencer time to finish bytes that caused nothing.
    task automatic settle();
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready; the shadow copy
    // is updated once the register has taken the value.
    task automatic write_reg(spr_pkg::cfg_reg_t idx, logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            spr_pkg::REG_PATTERN_BYTES:     pat_word     = value;
            spr_pkg::REG_PATTERN_LEN:       pat_len_cfg  = value[3:0];
            spr_pkg::REG_REPLACEMENT_BYTES: repl_word    = value;
            spr_pkg::REG_REPLACEMENT_LEN:   repl_len_cfg = value[3:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [63:0] pat, logic [3:0] plen,
                             logic [63:0] repl, logic [3:0] rlen);
        settle();
        write_reg(spr_pkg::REG_PATTERN_BYTES, pat);
        write_reg(spr_pkg::REG_PATTERN_LEN, 64'(plen));
        write_reg(spr_pkg::REG_REPLACEMENT_BYTES, repl);
        write_reg(spr_pkg::REG_REPLACEMENT_LEN, 64'(rlen));
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [63:0] pat;
        logic [63:0] repl;
        logic [3:0]  plen;
        logic [3:0]  rlen;
        logic [7:0]  alpha;
        logic [7:0]  text[$];
        int          eff;
        int          pick;
        int          k;
        int          n;
        int          phase_count;
        int          random_count;
        bit          open;

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset config has an empty pattern and an empty replacement, so the
        // string passes through unchanged. Extreme byte values on the way.
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);

        // Pattern "ab" to "XYZ". The first 'a' of "aab" must be released when
        // the second one arrives; a trailing 'a' is flushed at string end.
        configure(64'h6261, 4'd2, 64'h5A5958, 4'd3);
        send_text("aab", 1'b1);
        send_text("ba", 1'b1);

        // Deletion with the pattern "aab". The second string is
        // one whole match ending on its last byte, which leaves nothing to
        // send but the bare end marker.
        configure(64'h626161, 4'd3, 64'h0, 4'd0);
        send_text("aaab", 1'b1);
        send_text("aab", 1'b1);

        // Oversized lengths saturate to a full eight-byte pattern and an
        // eight-byte replacement.
        pat = 64'h00FF_00FF_00FF_00FF;
        configure(pat, 4'd15, 64'h8877_6655_4433_2211, 4'd12);
        for (k = 0; k < 8; k++)
            queue_byte(pat[8*k +: 8], k == 7);

        // Leave five pattern bytes held mid-string, then switch to an empty
        // pattern: the held bytes come out ahead of the inserted text.
        for (k = 0; k < 5; k++)
            queue_byte(pat[8*k +: 8], 1'b0);
        configure(64'h0, 4'd0, 64'h4241, 4'd2);
        queue_byte(8'h7E, 1'b1);

        // Random phases. Most pick a pattern over a small alphabet so that
        // strings built from whole patterns, partial prefixes and stray
        // letters exercise matches, overlaps and rescans. The last string of a
        // phase is sometimes left open so held bytes meet the new settings.
        random_count = 0;
        while (random_count < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 9);
            plen = (pick == 0) ? 4'd0 : (pick == 1) ? 4'd8 :
                   (pick == 2) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 4));
            pick = $urandom_range(0, 9);
            rlen = (pick == 0) ? 4'd0 : (pick == 1) ? 4'd8 :
                   (pick == 2) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 5));
            alpha = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0)
                pat = {$urandom, $urandom};
            else
                for (k = 0; k < 8; k++)
                    pat[8*k +: 8] = alpha + 8'($urandom_range(0, 1));
            repl = {$urandom, $urandom};
            configure(pat, plen, repl, rlen);
            eff      = (plen > 8) ? 8 : int'(plen);
            gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 8;
            sink_max = ($urandom_range(0, 3) == 0) ? 0 : 8;

            phase_count = 0;
            while (phase_count < 24)
            begin
                text.delete();
                repeat ($urandom_range(1, 5))
                begin
                    pick = (eff == 0) ? 7 + $urandom_range(0, 2) : $urandom_range(0, 9);
                    if (pick <= 4)
                        for (k = 0; k < eff; k++)
                            text.push_back(pat[8*k +: 8]);
                    else if (pick <= 6)
                    begin
                        n = $urandom_range(1, (eff > 1) ? eff - 1 : 1);
                        for (k = 0; k < n; k++)
                            text.push_back(pat[8*k +: 8]);
                    end
                    else if (pick <= 8)
                        text.push_back(alpha + 8'($urandom_range(0, 2)));
                    else
                        text.push_back(8'($urandom_range(0, 255)));
                end
                open = (phase_count + text.size() >= 24) && ($urandom_range(0, 2) == 0);
                for (k = 0; k < text.size(); k++)
                    queue_byte(text[k], !open && (k == text.size() - 1));
                phase_count += text.size();
                // Now and then the source waits for the block to catch up.
                if ($urandom_range(0, 5) == 0)
                    wait_drain();
            end
            random_count += phase_count;
        end

        // Close any string left open by the last phase.
        queue_byte(8'($urandom_range(0, 255)), 1'b1);

        settle();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/spr_pkg.sv
rtl/spr_front.sv
rtl/spr_back.sv
rtl/spr_out.sv
rtl/stream_pattern_replace.sv
verif/testbench.sv
